/* src/ckss_pkg.sv */
package ckss_pkg;

	localparam int unsigned MASK_W       = 16;
	localparam int unsigned MASK_IDX_W   = $clog2(MASK_W);
	localparam int unsigned KEY_W        = 5;
	localparam int unsigned INTERVAL_W   = 20;
	localparam int unsigned PULSE_W      = 8;
	localparam int unsigned TOTAL_W      = 32;
	localparam int unsigned CFG_DATA_W   = 20;
	localparam int unsigned CFG_INDEX_W  = 1;
	localparam int unsigned S_TDATA_W    = 8;
	localparam int unsigned M_TDATA_W    = 88;
	localparam int unsigned KEY_COUNT_DEF = 16;

	localparam logic [INTERVAL_W-1:0] SINCE_MAX        = '1;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET   = INTERVAL_W'(10000);
	localparam logic [PULSE_W-1:0]    PULSE_RESET      = PULSE_W'(3);

	localparam logic [CFG_INDEX_W-1:0] REG_POLL_INTERVAL = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_PULSE_TICKS   = 1'b1;

	typedef struct packed {
		logic               scan_done;
		logic [TOTAL_W-1:0] scan_total;
		logic               key_new_release;
		logic               key_new_press;
		logic               key_down;
		logic [MASK_W-1:0]  release_edge_mask;
		logic [MASK_W-1:0]  press_edge_mask;
		logic [MASK_W-1:0]  key_mask;
		logic               scl_level;
	} result_t;

endpackage

/* src/ckss_core.sv */
module ckss_core import ckss_pkg::*; #(
	parameter int unsigned KEY_COUNT = KEY_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  sdo_level,
	input  logic [KEY_W-1:0]      key_number,
	input  logic [INTERVAL_W-1:0] poll_interval_ticks,
	input  logic [PULSE_W-1:0]    pulse_ticks,
	output result_t               result
);

	localparam int unsigned IDX_W = $clog2(KEY_COUNT + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_COUNT);
	localparam logic [KEY_W-1:0] KEY_MAX  = KEY_W'(KEY_COUNT);

	typedef enum logic [2:0] {
		IDLE,
		START_LO,
		BIT_LO,
		BIT_HI,
		END_HI
	} phase_t;

	phase_t                phase_q, phase_n;
	logic [IDX_W-1:0]      bit_idx_q, bit_idx_n;
	logic [PULSE_W-1:0]    ticks_q, ticks_n;
	logic [MASK_W-1:0]     shift_q, shift_n;
	logic [MASK_W-1:0]     cur_q, cur_n;
	logic [MASK_W-1:0]     prev_q, prev_n;
	logic [INTERVAL_W-1:0] since_q, since_n;
	logic [TOTAL_W-1:0]    total_q, total_n;

	logic [INTERVAL_W-1:0] interval_eff, since_inc;
	logic [PULSE_W-1:0]    pulse_eff, ticks_inc;
	logic [IDX_W-1:0]      bit_idx_inc;
	logic                  scl, done;
	logic [MASK_W-1:0]     press, release_m;
	logic [KEY_W-1:0]      key_sel;
	logic                  key_ok;

	assign interval_eff = (poll_interval_ticks == '0) ? INTERVAL_W'(1) : poll_interval_ticks;
	assign pulse_eff    = (pulse_ticks == '0) ? PULSE_W'(1) : pulse_ticks;
	assign since_inc    = (since_q != SINCE_MAX) ? since_q + INTERVAL_W'(1) : since_q;

	always_comb begin
		phase_n   = phase_q;
		bit_idx_n = bit_idx_q;
		ticks_n   = ticks_q;
		shift_n   = shift_q;
		cur_n     = cur_q;
		prev_n    = prev_q;
		since_n   = since_inc;
		total_n   = total_q;
		scl       = 1'b1;
		done      = 1'b0;

		// start a read when idle and the poll interval has run out
		if (phase_q == IDLE && since_inc >= interval_eff) begin
			phase_n   = START_LO;
			ticks_n   = '0;
			bit_idx_n = '0;
			shift_n   = '0;
			since_n   = '0;
		end

		ticks_inc   = ticks_n + PULSE_W'(1);
		bit_idx_inc = bit_idx_n + IDX_W'(1);

		if (phase_n != IDLE) begin
			scl = !(phase_n == START_LO || phase_n == BIT_LO);
			if (ticks_inc >= pulse_eff) begin
				ticks_n = '0;
				unique case (phase_n)
					START_LO: phase_n = BIT_LO;
					BIT_LO: begin
						if (!sdo_level)
							shift_n[MASK_IDX_W'(bit_idx_n)] = 1'b1;
						phase_n = BIT_HI;
					end
					BIT_HI: begin
						bit_idx_n = bit_idx_inc;
						phase_n   = (bit_idx_inc >= LAST_IDX) ? END_HI : BIT_LO;
					end
					END_HI: begin
						prev_n    = cur_q;
						cur_n     = shift_n;
						total_n   = total_q + TOTAL_W'(1);
						done      = 1'b1;
						phase_n   = IDLE;
						bit_idx_n = '0;
					end
					default: phase_n = IDLE;
				endcase
			end else begin
				ticks_n = ticks_inc;
			end
		end
	end

	assign press     = cur_n & ~prev_n;
	assign release_m = ~cur_n & prev_n;
	assign key_sel   = key_number - KEY_W'(1);
	assign key_ok    = (key_number != '0) && (key_number <= KEY_MAX);

	always_comb begin
		result.scl_level         = scl;
		result.key_mask          = cur_n;
		result.press_edge_mask   = press;
		result.release_edge_mask = release_m;
		result.key_down          = key_ok & cur_n[key_sel[MASK_IDX_W-1:0]];
		result.key_new_press     = key_ok & press[key_sel[MASK_IDX_W-1:0]];
		result.key_new_release   = key_ok & release_m[key_sel[MASK_IDX_W-1:0]];
		result.scan_total        = total_n;
		result.scan_done         = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= IDLE;
			bit_idx_q <= '0;
			ticks_q   <= '0;
			shift_q   <= '0;
			cur_q     <= '0;
			prev_q    <= '0;
			since_q   <= '0;
			total_q   <= '0;
		end else if (step) begin
			phase_q   <= phase_n;
			bit_idx_q <= bit_idx_n;
			ticks_q   <= ticks_n;
			shift_q   <= shift_n;
			cur_q     <= cur_n;
			prev_q    <= prev_n;
			since_q   <= since_n;
			total_q   <= total_n;
		end
	end

endmodule

/* src/capacitive_keypad_serial_scanner.sv */
// Two-wire serial touch keypad reader. Each request on the slave side is one
// tick of the time base and carries the data pin level and a key number to
// query; each tick gives exactly one result on the master side with the clock
// level to drive, the latest key mask, the press and release edge masks, the
// queried key's answers (zero for key 0 or above KEY_COUNT), the scan count
// and a flag set on the tick that completed a scan. A read starts once
// poll_interval_ticks ticks have passed since the last read began, holds the
// clock low for a start half phase, then reads KEY_COUNT bits LSB first (data low
// means touched, sampled on the last tick of each low phase) and ends with one
// high half phase; every half phase lasts pulse_ticks ticks. A register value
// of zero acts as one. The block takes one tick per clock cycle while the
// master side accepts results; the input register takes each request, and the
// scanner step then carries it into the result register, which offers it.
// Input ready follows output ready through the two stages, so a stalled master
// side holds at most two ticks.
// Write the configuration registers only while no tick is in flight.
module capacitive_keypad_serial_scanner import ckss_pkg::*; #(
	parameter int unsigned KEY_COUNT = KEY_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	// tick requests
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_TDATA_W-1:0]   s_tdata,  // [0] sdo_level, [5:1] key_number, [7:6] zero
	// results
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] scl_level, [16:1] key_mask, [32:17] press_edge_mask,
	// [48:33] release_edge_mask, [49] key_down, [50] key_new_press,
	// [51] key_new_release, [83:52] scan_total, [84] scan_done, [87:85] zero
	output logic [M_TDATA_W-1:0]   m_tdata
);

	logic [INTERVAL_W-1:0] interval_q;
	logic [PULSE_W-1:0]    pulse_q;

	logic                  valid_s1;
	logic                  sdo_s1;
	logic [KEY_W-1:0]      key_s1;

	logic                  out_valid_q;
	result_t               res_q;
	result_t               res_next;
	logic                  advance;

	// configuration registers; unknown indexes fall through untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
			pulse_q    <= PULSE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_POLL_INTERVAL: interval_q <= wr_data[INTERVAL_W-1:0];
				REG_PULSE_TICKS:   pulse_q    <= wr_data[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the held tick into the result register when that register is empty or its result is being taken
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload of the input stage; hold while stalled
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sdo_s1 <= s_tdata[0];
			key_s1 <= s_tdata[KEY_W:1];
		end
	end

	ckss_core #(
		.KEY_COUNT(KEY_COUNT)
	) u_core (
		.clk                (clk),
		.arst_n             (arst_n),
		.step               (advance),
		.sdo_level          (sdo_s1),
		.key_number         (key_s1),
		.poll_interval_ticks(interval_q),
		.pulse_ticks        (pulse_q),
		.result             (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, res_q};

endmodule
